// File: rtl/swerve_module_kinematics_assert.svh
// Assertion macros for the swerve kinematics block
`ifndef SWERVE_MODULE_KINEMATICS_ASSERT_SVH
`define SWERVE_MODULE_KINEMATICS_ASSERT_SVH
// implication that holds at every edge out of reset
`define SMK_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define SMK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/smk_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smk_pkg
// Shared constants, types and tables for the swerve kinematics pipeline.
// ---------------------------------------------------------------------------
package smk_pkg;
	localparam int CordicSteps = 16;
	localparam int IdxW = $clog2(CordicSteps + 1);
	// operands: 18-bit pair values scaled by 2^24, plus CORDIC growth
	localparam int CW = 46;
	localparam int ZW = 34;
	localparam int SqW = 36;
	localparam int RootW = 18;
	localparam logic [15:0] LenReset = 16'd25439;
	localparam logic [15:0] WidReset = 16'd20655;
	localparam logic CfgLen = 1'b0;
	localparam logic CfgWid = 1'b1;
	localparam logic signed [ZW-1:0] PiZ = 34'sd2147483648;

	typedef logic signed [17:0] pair_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cord_t;

	// root holds the partial result at the weight of the current bit pair
	typedef struct packed {
		logic [SqW-1:0] rem;
		logic [SqW-1:0] root;
	} sqrt_t;

	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		logic signed [ZW-1:0] t;
		case (i)
			0:  t = 34'sd536870912;
			1:  t = 34'sd316933406;
			2:  t = 34'sd167458907;
			3:  t = 34'sd85004756;
			4:  t = 34'sd42667331;
			5:  t = 34'sd21354465;
			6:  t = 34'sd10679838;
			7:  t = 34'sd5340245;
			8:  t = 34'sd2670163;
			9:  t = 34'sd1335087;
			10: t = 34'sd667544;
			11: t = 34'sd333772;
			12: t = 34'sd166886;
			13: t = 34'sd83443;
			14: t = 34'sd41722;
			15: t = 34'sd20861;
			16: t = 34'sd10430;
			17: t = 34'sd5215;
			18: t = 34'sd2608;
			19: t = 34'sd1304;
			20: t = 34'sd652;
			21: t = 34'sd326;
			22: t = 34'sd163;
			23: t = 34'sd81;
			default: t = '0;
		endcase
		return t;
	endfunction
endpackage

// File: rtl/smk_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smk_front
// Two stages: rotation times ratios, then the four pair values a, b, c, d.
// ---------------------------------------------------------------------------
module smk_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic signed [15:0]  strafe,
	input  logic signed [15:0]  forward,
	input  logic signed [15:0]  rotation,
	input  logic [15:0]         len_q,
	input  logic [15:0]         wid_q,
	output logic                vout,
	output smk_pkg::pair_t      a_s2,
	output smk_pkg::pair_t      b_s2,
	output smk_pkg::pair_t      c_s2,
	output smk_pkg::pair_t      d_s2
);
	logic signed [32:0] pl_s1, pw_s1;
	logic signed [16:0] sx_s1, fy_s1;
	logic               v_s1;
	logic signed [17:0] rl, rw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			vout <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= 33'(rotation * $signed({1'b0, len_q}));
			pw_s1 <= 33'(rotation * $signed({1'b0, wid_q}));
			sx_s1 <= 17'(strafe);
			fy_s1 <= -17'(forward);
		end
	end

	assign rl = 18'((pl_s1 + 33'sd16384) >>> 15);
	assign rw = 18'((pw_s1 + 33'sd16384) >>> 15);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= 18'(sx_s1) - rl;
			b_s2 <= 18'(sx_s1) + rl;
			c_s2 <= 18'(fy_s1) - rw;
			d_s2 <= 18'(fy_s1) + rw;
		end
	end
endmodule

// File: rtl/smk_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smk_lane
// One module: pipelined CORDIC vectoring for the angle and a bit-pair
// square root pipeline for the speed, both one step per stage.
// ---------------------------------------------------------------------------
module smk_lane (
	input  logic               clk,
	input  logic               en,
	input  smk_pkg::pair_t     p,
	input  smk_pkg::pair_t     q,
	output logic [15:0]        speed,
	output logic signed [15:0] angle
);
	localparam int N = smk_pkg::CordicSteps;
	localparam int SqS = smk_pkg::RootW;
	localparam int SqW = smk_pkg::SqW;
	localparam int CW = smk_pkg::CW;
	localparam int ZW = smk_pkg::ZW;

	// depth: the larger of the square stage + SqS root steps and 1 + N CORDIC steps
	localparam int Lat = (N + 1 > SqS + 1) ? N + 1 : SqS + 1;

	smk_pkg::cord_t cs_s [0:Lat];
	smk_pkg::sqrt_t sq_s [0:Lat];
	logic [SqW-1:0] pp, qq;

	assign pp = SqW'($signed(p) * $signed(p));
	assign qq = SqW'($signed(q) * $signed(q));

	// stage 0: pre-rotation and squares
	always_ff @(posedge clk) begin
		if (en) begin
			cs_s[0].zero <= (p == '0) && (q == '0);
			if (q < 0) begin
				cs_s[0].z <= (p >= 0) ? smk_pkg::PiZ : -smk_pkg::PiZ;
				cs_s[0].x <= CW'(-q) <<< 24;
				cs_s[0].y <= CW'(-p) <<< 24;
			end else begin
				cs_s[0].z <= '0;
				cs_s[0].x <= CW'(q) <<< 24;
				cs_s[0].y <= CW'(p) <<< 24;
			end
			sq_s[0].rem  <= pp + qq;
			sq_s[0].root <= '0;
		end
	end

	genvar g;
	generate
		for (g = 0; g < Lat; g++) begin : g_st
			smk_pkg::cord_t cn;
			smk_pkg::sqrt_t sn;
			always_comb begin
				cn = cs_s[g];
				if (g < N) begin
					if (!cs_s[g].y[CW-1]) begin
						cn.x = cs_s[g].x + (cs_s[g].y >>> g);
						cn.y = cs_s[g].y - (cs_s[g].x >>> g);
						cn.z = cs_s[g].z + smk_pkg::atan_tab(g);
					end else begin
						cn.x = cs_s[g].x - (cs_s[g].y >>> g);
						cn.y = cs_s[g].y + (cs_s[g].x >>> g);
						cn.z = cs_s[g].z - smk_pkg::atan_tab(g);
					end
				end
			end
			// restoring root, one result bit per stage from the top
			always_comb begin
				logic [SqW-1:0] bitv, trial;
				bitv = '0;
				trial = '0;
				sn = sq_s[g];
				if (g < SqS) begin
					bitv = SqW'(1) << (2 * (SqS - 1 - g));
					trial = sq_s[g].root + bitv;
					if (sq_s[g].rem >= trial) begin
						sn.rem = sq_s[g].rem - trial;
						sn.root = (sq_s[g].root >> 1) + bitv;
					end else begin
						sn.root = sq_s[g].root >> 1;
					end
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					cs_s[g+1] <= cn;
					sq_s[g+1] <= sn;
				end
			end
		end
	endgenerate

	logic signed [ZW-1:0] zr;
	logic signed [ZW-17:0] zo;
	assign zr = cs_s[Lat].z + ZW'(32768);
	assign zo = zr[ZW-1:16];

	always_comb begin
		if (cs_s[Lat].zero)
			angle = '0;
		else if (zo > 32767)
			angle = 16'sd32767;
		else if (zo < -32768)
			angle = -16'sd32768;
		else
			angle = 16'(zo);
		speed = (|sq_s[Lat].root[SqW-1:17]) ? 16'hFFFF : sq_s[Lat].root[16:1];
	end
endmodule

// File: rtl/swerve_module_kinematics.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swerve_module_kinematics
// Swerve inverse kinematics: four wheel speeds and steering angles.
// ---------------------------------------------------------------------------
// channel   signals                          direction
// cfg       cfg_we, cfg_idx, cfg_data        in, write only
// command   in_valid/in_ready, 3 axes        in
// result    out_valid/out_ready, 8 fields    out
// One command per cycle unless the output stalls; 2 front stages, 20 lane stages.
// The lane depth is set by the square-root steps, one result bit each.
// A stall on out_ready freezes the whole pipe; in_ready drops with it.
// Reset clears valid bits and loads the default ratios.
`include "swerve_module_kinematics_assert.svh"
module swerve_module_kinematics (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] strafe,
	input  logic signed [15:0] forward,
	input  logic signed [15:0] rotation,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        speed_back_right,
	output logic [15:0]        speed_back_left,
	output logic [15:0]        speed_front_right,
	output logic [15:0]        speed_front_left,
	output logic signed [15:0] angle_back_right,
	output logic signed [15:0] angle_back_left,
	output logic signed [15:0] angle_front_right,
	output logic signed [15:0] angle_front_left
);
	localparam int Lat = (smk_pkg::CordicSteps > smk_pkg::RootW) ?
		smk_pkg::CordicSteps + 1 : smk_pkg::RootW + 1;

	logic [15:0] len_q, wid_q;
	logic        en, fv;
	// one valid bit per lane register stage, input stage included
	logic [Lat:0] v_q;
	smk_pkg::pair_t a, b, c, d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= smk_pkg::LenReset;
			wid_q <= smk_pkg::WidReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				smk_pkg::CfgLen: len_q <= cfg_data;
				smk_pkg::CfgWid: wid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances together; holds when the head result is not taken
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign out_valid = v_q[Lat];

	smk_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(in_valid),
		.strafe(strafe), .forward(forward), .rotation(rotation),
		.len_q(len_q), .wid_q(wid_q), .vout(fv),
		.a_s2(a), .b_s2(b), .c_s2(c), .d_s2(d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[Lat-1:0], fv};
	end

	smk_lane u_br (.clk(clk), .en(en), .p(a), .q(d),
		.speed(speed_back_right), .angle(angle_back_right));
	smk_lane u_bl (.clk(clk), .en(en), .p(a), .q(c),
		.speed(speed_back_left), .angle(angle_back_left));
	smk_lane u_fr (.clk(clk), .en(en), .p(b), .q(d),
		.speed(speed_front_right), .angle(angle_front_right));
	smk_lane u_fl (.clk(clk), .en(en), .p(b), .q(c),
		.speed(speed_front_left), .angle(angle_front_left));

	`SMK_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
	`SMK_ASSERT_IMP(a_ready, !out_valid, in_ready)
	`SMK_ASSERT_NEXT(a_stall, out_valid && !out_ready, $stable(v_q))
endmodule
